### rtl/q2e_pkg.sv
// Shared types, constants and the arctangent table for the quaternion to
// Euler angle block. No dependencies.

package q2e_pkg;

    localparam int TERM_W       = 31;   // rotation term, Q.28, saturated to +-2
    localparam int CW           = 34;   // CORDIC vector width
    localparam int ZW           = 34;   // CORDIC angle width, Q.30 radians
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_N     = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    localparam int SQRT_BITS    = 30;   // result bits of the magnitude root
    localparam int SUM_W        = 60;   // sum of two squared terms
    localparam int RES_W        = 61;   // root accumulator with headroom
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_AW      = 2;
    localparam int FMT_STAGES   = 2;
    localparam int BACK_LAT     = 2 + SQRT_BITS + 1 + CORDIC_N + FMT_STAGES;

    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [23:0]   DEG_FACTOR  = 24'sd3754936;

    typedef logic signed [TERM_W-1:0] term_t;
    typedef logic signed [CW-1:0]     cvec_t;
    typedef logic signed [ZW-1:0]     zang_t;
    typedef logic signed [15:0]       angle_t;

    typedef struct packed {
        term_t r11;
        term_t r21;
        term_t r31;
        term_t r32;
        term_t r33;
    } terms_t;

    function automatic zang_t atan_q30(input int i);
        zang_t a;
        case (i)
            0:  a = 34'sd843314857;
            1:  a = 34'sd497837829;
            2:  a = 34'sd263043837;
            3:  a = 34'sd133525159;
            4:  a = 34'sd67021687;
            5:  a = 34'sd33543516;
            6:  a = 34'sd16775851;
            7:  a = 34'sd8388437;
            8:  a = 34'sd4194283;
            9:  a = 34'sd2097149;
            10: a = 34'sd1048576;
            11: a = 34'sd524288;
            12: a = 34'sd262144;
            13: a = 34'sd131072;
            14: a = 34'sd65536;
            15: a = 34'sd32768;
            16: a = 34'sd16384;
            17: a = 34'sd8192;
            18: a = 34'sd4096;
            19: a = 34'sd2048;
            20: a = 34'sd1024;
            21: a = 34'sd512;
            22: a = 34'sd256;
            23: a = 34'sd128;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

### rtl/q2e_front.sv
// Front end: accepts quaternions and forms the five saturated rotation terms
// in two registered stages. Depends on q2e_pkg.

module q2e_front
    import q2e_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [15:0]  s_quat_w,
    input  logic signed [15:0]  s_quat_x,
    input  logic signed [15:0]  s_quat_y,
    input  logic signed [15:0]  s_quat_z,
    input  logic                q_full,
    output logic                q_push,
    output terms_t              q_push_data
);

    function automatic term_t sat_term(input logic signed [34:0] v);
        if (v > 35'sd536870912) begin
            return 31'sd536870912;
        end else if (v < -35'sd536870912) begin
            return -31'sd536870912;
        end
        return term_t'(v);
    endfunction

    logic signed [31:0] ww_reg, xx_reg, zz_reg, xy_reg, wz_reg;
    logic signed [31:0] xz_reg, wy_reg, yz_reg, wx_reg;
    logic               f1_valid_reg, f2_valid_reg;
    terms_t             terms_reg, terms_next;
    logic               adv;

    // The second stage only blocks when it holds an item the queue cannot take.
    assign adv     = !f2_valid_reg || !q_full;
    assign s_ready = adv;
    assign q_push  = f2_valid_reg && !q_full;
    assign q_push_data = terms_reg;

    always_comb begin
        terms_next.r11 = sat_term((35'(ww_reg) <<< 1) - 35'sd268435456 + (35'(xx_reg) <<< 1));
        terms_next.r21 = sat_term((35'(xy_reg) - 35'(wz_reg)) <<< 1);
        terms_next.r31 = sat_term((35'(xz_reg) + 35'(wy_reg)) <<< 1);
        terms_next.r32 = sat_term((35'(yz_reg) - 35'(wx_reg)) <<< 1);
        terms_next.r33 = sat_term((35'(ww_reg) <<< 1) - 35'sd268435456 + (35'(zz_reg) <<< 1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end else if (adv) begin
            f1_valid_reg <= s_valid;
            f2_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ww_reg    <= s_quat_w * s_quat_w;
            xx_reg    <= s_quat_x * s_quat_x;
            zz_reg    <= s_quat_z * s_quat_z;
            xy_reg    <= s_quat_x * s_quat_y;
            wz_reg    <= s_quat_w * s_quat_z;
            xz_reg    <= s_quat_x * s_quat_z;
            wy_reg    <= s_quat_w * s_quat_y;
            yz_reg    <= s_quat_y * s_quat_z;
            wx_reg    <= s_quat_w * s_quat_x;
            terms_reg <= terms_next;
        end
    end

endmodule

### rtl/q2e_fifo.sv
// Short queue of rotation terms between the front and back ends.
// Depends on q2e_pkg.

module q2e_fifo
    import q2e_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  terms_t push_data,
    input  logic   pop,
    output logic   full,
    output logic   not_empty,
    output terms_t pop_data
);

    terms_t               mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]     count_reg;

    assign full      = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("queue read while empty");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("queue count beyond depth");

endmodule

### rtl/q2e_cordic.sv
// Pipelined CORDIC vectoring unit: one quadrant stage and one stage per
// micro-rotation, giving atan2(y, x) in Q.30 radians. Depends on q2e_pkg.

module q2e_cordic
    import q2e_pkg::*;
(
    input  logic  aclk,
    input  logic  en,
    input  cvec_t x_in,
    input  cvec_t y_in,
    output zang_t z_out
);

    cvec_t x_reg [CORDIC_N+1];
    cvec_t y_reg [CORDIC_N+1];
    zang_t z_reg [CORDIC_N+1];
    logic  zero_reg [CORDIC_N+1];

    assign z_out = zero_reg[CORDIC_N] ? '0 : z_reg[CORDIC_N];

    always_ff @(posedge aclk) begin
        if (en) begin
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
            if (x_in[CW-1] && !y_in[CW-1]) begin
                x_reg[0] <= y_in;
                y_reg[0] <= -x_in;
                z_reg[0] <= HALF_PI_Q30;
            end else if (x_in[CW-1]) begin
                x_reg[0] <= -y_in;
                y_reg[0] <= x_in;
                z_reg[0] <= -HALF_PI_Q30;
            end else begin
                x_reg[0] <= x_in;
                y_reg[0] <= y_in;
                z_reg[0] <= '0;
            end
            for (int i = 0; i < CORDIC_N; i++) begin
                zero_reg[i+1] <= zero_reg[i];
                if (!y_reg[i][CW-1]) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_q30(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_q30(i);
                end
            end
        end
    end

endmodule

### rtl/q2e_back.sv
// Back end: magnitude root, three CORDIC units and angle formatting, one
// pipeline that advances as a whole. Depends on q2e_pkg and q2e_cordic.

module q2e_back
    import q2e_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   deg_mode,
    input  logic   q_not_empty,
    input  terms_t q_data,
    output logic   q_pop,
    output logic   m_valid,
    input  logic   m_ready,
    output angle_t m_roll,
    output angle_t m_pitch,
    output angle_t m_yaw
);

    logic                    en;
    logic                    vld_reg [BACK_LAT];
    logic signed [61:0]      p32_reg, p33_reg;
    logic [SUM_W-1:0]        sum_reg;
    terms_t                  t0_reg, t1_reg;
    logic [RES_W-1:0]        v_reg   [SQRT_BITS];
    logic [RES_W-1:0]        res_reg [SQRT_BITS];
    terms_t                  tq_reg  [SQRT_BITS];
    cvec_t                   pitch_y, pitch_x, roll_y, roll_x, yaw_y, yaw_x;
    zang_t                   roll_z, pitch_z, yaw_z;
    zang_t                   fz_reg [3];
    logic signed [57:0]      fp_reg [3];
    angle_t                  out_reg [3];

    function automatic angle_t round_sat(input logic mode, input zang_t z,
                                         input logic signed [57:0] p);
        logic signed [57:0] r;
        if (mode) begin
            r = (p + 58'sd274877906944) >>> 39;
        end else begin
            r = (58'(z) + 58'sd65536) >>> 17;
        end
        if (r > 58'sd32767) begin
            return 16'sd32767;
        end else if (r < -58'sd32768) begin
            return -16'sd32768;
        end
        return angle_t'(r);
    endfunction

    // The whole back pipeline holds while a result waits at the output.
    assign en      = !m_valid || m_ready;
    assign q_pop   = en && q_not_empty;
    assign m_valid = vld_reg[BACK_LAT-1];
    assign m_roll  = out_reg[0];
    assign m_pitch = out_reg[1];
    assign m_yaw   = out_reg[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < BACK_LAT; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= q_not_empty;
            for (int i = 1; i < BACK_LAT; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // Squares, their sum, then one root bit per stage.
    always_ff @(posedge aclk) begin
        if (en) begin
            p32_reg <= q_data.r32 * q_data.r32;
            p33_reg <= q_data.r33 * q_data.r33;
            t0_reg  <= q_data;
            sum_reg <= SUM_W'(p32_reg) + SUM_W'(p33_reg);
            t1_reg  <= t0_reg;
            for (int k = 0; k < SQRT_BITS; k++) begin
                logic [RES_W-1:0] v, res, bitv;
                int               prev;
                prev = (k == 0) ? 0 : k - 1;
                bitv = RES_W'(1) << (2 * (SQRT_BITS - 1 - k));
                v    = (k == 0) ? RES_W'(sum_reg) : v_reg[prev];
                res  = (k == 0) ? '0 : res_reg[prev];
                if (v >= res + bitv) begin
                    v_reg[k]   <= v - (res + bitv);
                    res_reg[k] <= (res >> 1) + bitv;
                end else begin
                    v_reg[k]   <= v;
                    res_reg[k] <= res >> 1;
                end
                tq_reg[k] <= (k == 0) ? t1_reg : tq_reg[prev];
            end
        end
    end

    assign roll_y  = CW'(tq_reg[SQRT_BITS-1].r32);
    assign roll_x  = CW'(tq_reg[SQRT_BITS-1].r33);
    assign pitch_y = -CW'(tq_reg[SQRT_BITS-1].r31);
    assign pitch_x = CW'({1'b0, res_reg[SQRT_BITS-1][SQRT_BITS-1:0]});
    assign yaw_y   = CW'(tq_reg[SQRT_BITS-1].r21);
    assign yaw_x   = CW'(tq_reg[SQRT_BITS-1].r11);

    q2e_cordic u_roll  (.aclk(aclk), .en(en), .x_in(roll_x),  .y_in(roll_y),  .z_out(roll_z));
    q2e_cordic u_pitch (.aclk(aclk), .en(en), .x_in(pitch_x), .y_in(pitch_y), .z_out(pitch_z));
    q2e_cordic u_yaw   (.aclk(aclk), .en(en), .x_in(yaw_x),   .y_in(yaw_y),   .z_out(yaw_z));

    always_ff @(posedge aclk) begin
        if (en) begin
            fz_reg[0] <= roll_z;
            fz_reg[1] <= pitch_z;
            fz_reg[2] <= yaw_z;
            fp_reg[0] <= 58'(roll_z) * 58'(DEG_FACTOR);
            fp_reg[1] <= 58'(pitch_z) * 58'(DEG_FACTOR);
            fp_reg[2] <= 58'(yaw_z) * 58'(DEG_FACTOR);
            for (int a = 0; a < 3; a++) begin
                out_reg[a] <= round_sat(deg_mode, fz_reg[a], fp_reg[a]);
            end
        end
    end

endmodule

### rtl/quaternion_to_euler_angles.sv
// Top level of the quaternion to ZYX Euler angle converter.
// Depends on q2e_pkg, q2e_front, q2e_fifo and q2e_back.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid/s_ready    s_quat_w, s_quat_x, s_quat_y, s_quat_z
//   m_        out        m_valid/m_ready    m_roll_angle, m_pitch_angle, m_yaw_angle
//   cfg_      in         cfg_wr_en          cfg_wr_data (degree mode)
//
// One item is accepted per cycle while s_ready is high. An item passes the
// front end, the queue and the back end; the back end is the longest part,
// set by the one-bit-per-stage magnitude root and the CORDIC stages.
// Reset is synchronous and active low; it empties every valid stage and the
// queue and clears the degree mode to radians.
// A stall at the output freezes the back end; the front end keeps filling
// the four-entry queue and stalls s_ready only when the queue is full.

module quaternion_to_euler_angles
    import q2e_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [15:0]  s_quat_w,
    input  logic signed [15:0]  s_quat_x,
    input  logic signed [15:0]  s_quat_y,
    input  logic signed [15:0]  s_quat_z,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [15:0]  m_roll_angle,
    output logic signed [15:0]  m_pitch_angle,
    output logic signed [15:0]  m_yaw_angle
);

    logic   deg_mode_reg;
    logic   q_push, q_pop, q_full, q_not_empty;
    terms_t q_push_data, q_pop_data;

    // Degree mode: 0 gives radians Q2.13, 1 gives degrees Q8.7.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deg_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            deg_mode_reg <= cfg_wr_data;
        end
    end

    // The front end forms the rotation terms and hands them to the queue.
    q2e_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_quat_w    (s_quat_w),
        .s_quat_x    (s_quat_x),
        .s_quat_y    (s_quat_y),
        .s_quat_z    (s_quat_z),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_push_data (q_push_data)
    );

    q2e_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .pop_data  (q_pop_data)
    );

    // The back end takes the root, runs the CORDIC units and formats angles.
    q2e_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .deg_mode    (deg_mode_reg),
        .q_not_empty (q_not_empty),
        .q_data      (q_pop_data),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_roll      (m_roll_angle),
        .m_pitch     (m_pitch_angle),
        .m_yaw       (m_yaw_angle)
    );

endmodule

### test/tb_quaternion_to_euler_angles.sv
// Self-checking testbench for quaternion_to_euler_angles: drives quaternions,
// predicts roll, pitch and yaw in both angle units and compares every item.
// Depends on q2e_pkg and the RTL of the block; needs no files or arguments.

module tb_quaternion_to_euler_angles;
    import q2e_pkg::angle_t;
    import q2e_pkg::CORDIC_N;

    localparam int          CLEAR_WAIT = 70;      // longer than the pipe
    localparam int          LIMIT      = 300000;  // cycles before the run gives up
    localparam longint      ROT_MAX    = 64'sd1 << 29;
    localparam longint      HALF_PI    = 64'sd1686629713;
    localparam longint      DEG_SCALE  = 64'sd3754936;
    localparam int          PHASE_ITEMS = 170;

    typedef struct {
        angle_t roll;
        angle_t pitch;
        angle_t yaw;
    } euler_t;

    // One directed quaternion. Where roll_pitch_zero is set, both the roll
    // and the pitch vector are the zero vector, so both angles are exactly 0.
    typedef struct {
        logic signed [15:0] w, x, y, z;
        bit                 roll_pitch_zero;
    } quat_row_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic               cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    logic signed [15:0] s_quat_w, s_quat_x, s_quat_y, s_quat_z;
    logic               m_valid;
    logic               m_ready;
    logic signed [15:0] m_roll_angle, m_pitch_angle, m_yaw_angle;

    euler_t pending_angles[$];
    bit     units_deg;        // the predictor's copy of the degree mode
    int     send_idle_pct;
    int     recv_idle_pct;
    int     error_count;
    int     cycle_count;

    quaternion_to_euler_angles uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_quat_w      (s_quat_w),
        .s_quat_x      (s_quat_x),
        .s_quat_y      (s_quat_y),
        .s_quat_z      (s_quat_z),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_roll_angle  (m_roll_angle),
        .m_pitch_angle (m_pitch_angle),
        .m_yaw_angle   (m_yaw_angle)
    );

    // The arctangent steps atan(2^-i) in Q.30 radians.
    localparam longint STEP_ANGLE[24] = '{
        843314857, 497837829, 263043837, 133525159,
        67021687, 33543516, 16775851, 8388437,
        4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768,
        16384, 8192, 4096, 2048,
        1024, 512, 256, 128
    };

    // Rotation terms in Q.28 are clipped to +-2.
    function automatic longint clip_term(longint v);
        if (v > ROT_MAX) begin
            return ROT_MAX;
        end
        if (v < -ROT_MAX) begin
            return -ROT_MAX;
        end
        return v;
    endfunction

    // Floor of the square root, one result bit per pass.
    function automatic longint floor_root(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) begin
            bitv = bitv >> 2;
        end
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return longint'(res);
    endfunction

    // Vectoring CORDIC: angle of (vx, vy) in Q.30 radians, 0 for the zero
    // vector. A vector in the left half plane is first turned by a quarter
    // turn so that the micro-rotations only have to cover +-pi/2.
    function automatic longint vector_angle(longint vy, longint vx);
        longint ang;
        longint t;
        longint dx;
        longint dy;
        ang = 0;
        if (vx == 0 && vy == 0) begin
            return 0;
        end
        if (vx < 0) begin
            t = vx;
            if (vy >= 0) begin
                vx  = vy;
                vy  = -t;
                ang = HALF_PI;
            end else begin
                vx  = -vy;
                vy  = t;
                ang = -HALF_PI;
            end
        end
        for (int i = 0; i < CORDIC_N; i++) begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy >= 0) begin
                vx  = vx + dx;
                vy  = vy - dy;
                ang = ang + STEP_ANGLE[i];
            end else begin
                vx  = vx - dx;
                vy  = vy + dy;
                ang = ang - STEP_ANGLE[i];
            end
        end
        return ang;
    endfunction

    // Round half up into Q2.13 radians or Q8.7 degrees, then clip to 16 bits.
    function automatic angle_t round_angle(longint ang, bit deg);
        longint r;
        if (deg) begin
            r = (ang * DEG_SCALE + (64'sd1 << 38)) >>> 39;
        end else begin
            r = (ang + (64'sd1 << 16)) >>> 17;
        end
        if (r > 32767) begin
            r = 32767;
        end
        if (r < -32768) begin
            r = -32768;
        end
        return angle_t'(r);
    endfunction

    function automatic euler_t predict_euler(logic signed [15:0] qw, logic signed [15:0] qx,
                                             logic signed [15:0] qy, logic signed [15:0] qz,
                                             bit deg);
        longint w, x, y, z;
        longint one;
        longint r11, r21, r31, r32, r33;
        longint mag;
        euler_t e;
        w   = qw;
        x   = qx;
        y   = qy;
        z   = qz;
        one = 64'sd1 << 28;
        r11 = clip_term(2 * (w * w) - one + 2 * (x * x));
        r21 = clip_term(2 * (x * y - w * z));
        r31 = clip_term(2 * (x * z + w * y));
        r32 = clip_term(2 * (y * z - w * x));
        r33 = clip_term(2 * (w * w) - one + 2 * (z * z));
        mag = floor_root(longint'(r32 * r32) + longint'(r33 * r33));
        e.roll  = round_angle(vector_angle(r32, r33), deg);
        e.pitch = round_angle(vector_angle(-r31, mag), deg);
        e.yaw   = round_angle(vector_angle(r21, r11), deg);
        return e;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d at cycle %0d",
                 what, got, want, cycle_count);
        error_count++;
    endtask

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever begin
            #5 aclk = ~aclk;
        end
    end

    // Cycle counter and watchdog. A run that hangs on a handshake ends here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_quaternion_to_euler_angles: errors");
            $finish;
        end
    end

    // Result side: m_ready is drawn anew every cycle from the current idle
    // rate, and every item taken is compared with the oldest expectation.
    always @(posedge aclk) begin
        euler_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            if (m_valid && m_ready) begin
                if (pending_angles.size() == 0) begin
                    report_mismatch("item with nothing expected", m_roll_angle, 0);
                end else begin
                    want = pending_angles.pop_front();
                    if (m_roll_angle !== want.roll) begin
                        report_mismatch("roll", m_roll_angle, want.roll);
                    end
                    if (m_pitch_angle !== want.pitch) begin
                        report_mismatch("pitch", m_pitch_angle, want.pitch);
                    end
                    if (m_yaw_angle !== want.yaw) begin
                        report_mismatch("yaw", m_yaw_angle, want.yaw);
                    end
                end
            end
        end
    end

    // Present one quaternion and hold it until the block takes it. The
    // sender idles one cycle at a time at the current idle rate. The
    // expectation is queued at the edge of acceptance.
    task automatic send_quat(logic signed [15:0] w, logic signed [15:0] x,
                             logic signed [15:0] y, logic signed [15:0] z,
                             bit roll_pitch_zero);
        euler_t e;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_quat_w <= w;
        s_quat_x <= x;
        s_quat_y <= y;
        s_quat_z <= z;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        e = predict_euler(w, x, y, z, units_deg);
        if (roll_pitch_zero) begin
            e.roll  = '0;
            e.pitch = '0;
        end
        pending_angles.push_back(e);
    endtask

    // Let the pipe run dry, then switch the angle units while nothing moves.
    task automatic set_units(bit deg);
        s_valid <= 1'b0;
        wait (pending_angles.size() == 0);
        repeat (CLEAR_WAIT) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= deg;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        units_deg  = deg;
    endtask

    // Random quaternion: mostly unit length with random direction, some with
    // roll near +-90 degrees, and a share of raw 16-bit noise that saturates terms.
    task automatic send_random_quat();
        real a, b, c, d, n, k;
        int  pick;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1'b0);
        end else begin
            a = $itor($urandom_range(0, 32768)) - 16384.0;
            b = $itor($urandom_range(0, 32768)) - 16384.0;
            c = $itor($urandom_range(0, 32768)) - 16384.0;
            d = $itor($urandom_range(0, 32768)) - 16384.0;
            if (pick < 30) begin
                // Roll close to +-90 degrees with pitch near 0: wy = -xz nearly at its peak.
                a = 8192.0 + $itor($urandom_range(0, 64)) - 32.0;
                b = (($urandom_range(0, 1) == 1) ? 8192.0 : -8192.0);
                c = a;
                d = -b + $itor($urandom_range(0, 64)) - 32.0;
            end
            n = $sqrt(a * a + b * b + c * c + d * d);
            if (n < 1.0) begin
                send_quat(16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b0);
            end else begin
                k = 16384.0 / n;
                send_quat(16'($rtoi(a * k)), 16'($rtoi(b * k)), 16'($rtoi(c * k)),
                          16'($rtoi(d * k)), 1'b0);
            end
        end
    endtask

    quat_row_t directed_rows[12] = '{
        '{16'sd16384,  16'sd0,      16'sd0,      16'sd0,      1'b0},  // identity
        '{-16'sd16384, 16'sd0,      16'sd0,      16'sd0,      1'b0},  // same rotation, sign flipped
        '{16'sd0,      16'sd16384,  16'sd0,      16'sd0,      1'b0},  // roll by half a turn
        '{16'sd0,      16'sd0,      16'sd16384,  16'sd0,      1'b0},  // pitch by half a turn
        '{16'sd0,      16'sd0,      16'sd0,      16'sd16384,  1'b0},  // yaw by half a turn
        '{16'sd8192,   16'sd8192,   16'sd8192,   16'sd8192,   1'b0},  // gimbal lock, pitch -90
        '{16'sd8192,   -16'sd8192,  16'sd8192,   -16'sd8192,  1'b0},  // gimbal lock, pitch -90
        '{16'sd8192,   16'sd0,      16'sd0,      16'sd8192,   1'b1},  // roll and pitch of zero vector
        '{16'sd0,      16'sd0,      16'sd0,      16'sd0,      1'b0},  // null quaternion
        '{-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384, 1'b0},  // non-unit, terms saturate
        '{16'sh7fff,   16'sh7fff,   16'sh7fff,   16'sh7fff,   1'b0},  // largest codes
        '{-16'sh8000,  -16'sh8000,  16'sh7fff,   -16'sh8000,  1'b0}   // most negative codes
    };

    initial begin
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = 1'b0;
        s_valid        = 1'b0;
        s_quat_w       = '0;
        s_quat_x       = '0;
        s_quat_y       = '0;
        s_quat_z       = '0;
        units_deg      = 1'b0;
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        error_count    = 0;
        cycle_count    = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows, first in the reset units (radians), then in degrees.
        for (int u = 0; u < 2; u++) begin
            if (u == 1) begin
                set_units(1'b1);
            end
            foreach (directed_rows[r]) begin
                send_quat(directed_rows[r].w, directed_rows[r].x, directed_rows[r].y,
                          directed_rows[r].z, directed_rows[r].roll_pitch_zero);
            end
        end

        // Random phases: busy receiver with a quicker sender, the reverse, then
        // full rate. The units alternate so both settings see random traffic.
        for (int ph = 0; ph < 3; ph++) begin
            set_units(ph != 1);
            send_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 80 : 0;
            recv_idle_pct = (ph == 0) ? 80 : (ph == 1) ? 23 : 0;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (ph == 0 && i == PHASE_ITEMS / 2) begin
                    // Hold off until the pipe has delivered everything.
                    s_valid <= 1'b0;
                    wait (pending_angles.size() == 0);
                    @(posedge aclk);
                end
                send_random_quat();
            end
        end
        s_valid <= 1'b0;

        wait (pending_angles.size() == 0);
        repeat (CLEAR_WAIT) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb_quaternion_to_euler_angles: clean");
        end else begin
            $display("tb_quaternion_to_euler_angles: errors");
        end
        $finish;
    end

endmodule
